FILE: hw/rtl/hto_pkg.sv
// Package for the humidity/temperature outlier filter.
// Holds the request and result types, configuration codes and the fixed-point constants.
// Self-contained; used by every module of the block.
package hto_pkg;

    localparam int TEMP_W = 26;
    localparam int HUM_W  = 24;

    localparam logic [16:0] UNIT = 17'd131070;

    localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = 26'sd5898150;
    localparam logic signed [TEMP_W-1:0] TEMP_HIGH   = 26'sd16383750;
    localparam logic signed [TEMP_W-1:0] TEMP_LOW    = -26'sd5242800;
    localparam logic        [HUM_W-1:0]  HUM_FULL    = 24'd13107000;

    localparam logic signed [TEMP_W-1:0] TEMP_REC_RESET = 26'sd1310700;
    localparam logic        [HUM_W-1:0]  HUM_REC_RESET  = 24'd5242800;

    localparam logic [25:0] TEMP_JUMP_RESET = 26'd3932100;
    localparam logic [23:0] HUM_JUMP_RESET  = 24'd1310700;
    localparam logic [23:0] HUM_LOW_RESET   = 24'd1966050;

    localparam longint unsigned TENTH_DIV = 64'd13107;
    localparam int              DIV_SHIFT = 40;
    localparam int              RECIP_W   = 27;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + TENTH_DIV - 64'd1) / TENTH_DIV);
    localparam int QUOT_W = 11;

    localparam logic signed [11:0] FAULT_TEMP_TENTHS = 12'sd1300;

    typedef enum logic [1:0] {
        CFG_TEMP_JUMP = 2'd0,
        CFG_HUM_JUMP  = 2'd1,
        CFG_HUM_LOW   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] temp_code;
        logic [15:0] hum_code;
        logic        read_ok;
    } t_in_item;

    typedef struct packed {
        logic signed [11:0] temp_tenths;
        logic        [9:0]  hum_tenths;
        logic               read_failed;
    } t_out_item;

    typedef struct packed {
        logic [25:0] temp_jump;
        logic [23:0] hum_jump;
        logic [23:0] hum_low;
    } t_cfg;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic        [HUM_W-1:0]  hum;
        logic                     failed;
    } t_res;

endpackage

FILE: hw/rtl/hto_filter.sv
// Filter stage: outlier test, resampling burst, median-pair average and records.
// Depends on hto_pkg; feeds hto_tenths with values in units of 1/131070.
module hto_filter (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hto_pkg::t_cfg   i_cfg,
    input  logic            i_take,
    input  hto_pkg::t_in_item i_item,
    input  logic            i_adv,
    output logic            o_valid,
    output hto_pkg::t_res   o_res
);

    function automatic logic [16:0] mid_pair_sum(input logic [15:0] a, input logic [15:0] b,
                                                 input logic [15:0] c, input logic [15:0] d);
        logic [15:0] lo1;
        logic [15:0] hi1;
        logic [15:0] lo2;
        logic [15:0] hi2;
        lo1 = (a < b) ? a : b;
        hi1 = (a < b) ? b : a;
        lo2 = (c < d) ? c : d;
        hi2 = (c < d) ? d : c;
        return 17'((lo1 > lo2) ? lo1 : lo2) + 17'((hi1 < hi2) ? hi1 : hi2);
    endfunction

    logic        r_collecting, n_collecting;
    logic [1:0]  r_idx, n_idx;
    logic [15:0] r_tsamp [4];
    logic [15:0] r_hsamp [4];
    logic signed [hto_pkg::TEMP_W-1:0] r_trec, n_trec;
    logic        [hto_pkg::HUM_W-1:0]  r_hrec, n_hrec;
    logic          r_valid, n_valid;
    hto_pkg::t_res r_res;

    logic [15:0] tc, hc;
    logic [16:0] t_mid, h_mid;
    logic signed [hto_pkg::TEMP_W-1:0] t_dir, t_burst, t_cand, t_fin;
    logic        [hto_pkg::HUM_W-1:0]  h_dir, h_burst, h_cand, h_fin;
    logic signed [26:0] t_diff;
    logic        [26:0] t_adiff;
    logic signed [25:0] h_diff;
    logic        [25:0] h_adiff;
    logic trigger, last, ok_cand, produce;

    assign tc = i_item.temp_code;
    assign hc = {i_item.hum_code[15:2], 2'b00};

    assign t_mid = mid_pair_sum(r_tsamp[0], r_tsamp[1], r_tsamp[2], tc);
    assign h_mid = mid_pair_sum(r_hsamp[0], r_hsamp[1], r_hsamp[2], hc);

    assign t_dir   = $signed({1'b0, 25'(tc) * 25'd350}) - hto_pkg::TEMP_OFFSET;
    assign h_dir   = 24'(hc) * 24'd200;
    assign t_burst = $signed({1'b0, 25'(t_mid) * 25'd175}) - hto_pkg::TEMP_OFFSET;
    assign h_burst = 24'(h_mid) * 24'd100;

    assign t_diff  = 27'(t_dir) - 27'(r_trec);
    assign t_adiff = t_diff[26] ? 27'(-t_diff) : 27'(t_diff);
    assign h_diff  = $signed({2'b00, h_dir}) - $signed({2'b00, r_hrec});
    assign h_adiff = h_diff[25] ? 26'(-h_diff) : 26'(h_diff);

    assign trigger = !i_item.read_ok
                  || (t_adiff > {1'b0, i_cfg.temp_jump})
                  || (h_dir < i_cfg.hum_low)
                  || (h_dir >= hto_pkg::HUM_FULL)
                  || (h_adiff > {2'b00, i_cfg.hum_jump});

    assign last    = r_collecting && (r_idx == 2'd3);
    assign t_cand  = r_collecting ? t_burst : t_dir;
    assign h_cand  = r_collecting ? h_burst : h_dir;
    assign ok_cand = r_collecting ? i_item.read_ok : 1'b1;
    assign produce = i_take && (r_collecting ? last : !trigger);

    assign t_fin = (t_cand > hto_pkg::TEMP_HIGH || t_cand < hto_pkg::TEMP_LOW) ? r_trec : t_cand;
    assign h_fin = (h_cand >= hto_pkg::HUM_FULL) ? r_hrec : h_cand;

    always_comb begin
        n_collecting = r_collecting;
        n_idx        = r_idx;
        n_trec       = r_trec;
        n_hrec       = r_hrec;
        n_valid      = r_valid;
        if (i_adv) begin
            n_valid = 1'b0;
        end
        if (produce) begin
            n_valid = 1'b1;
            if (ok_cand) begin
                n_trec = t_fin;
                n_hrec = h_fin;
            end
        end
        if (i_take) begin
            if (r_collecting) begin
                if (last) begin
                    n_collecting = 1'b0;
                    n_idx        = 2'd0;
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end else if (trigger) begin
                n_collecting = 1'b1;
                n_idx        = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_collecting <= 1'b0;
            r_idx        <= 2'd0;
            r_trec       <= hto_pkg::TEMP_REC_RESET;
            r_hrec       <= hto_pkg::HUM_REC_RESET;
            r_valid      <= 1'b0;
        end else begin
            r_collecting <= n_collecting;
            r_idx        <= n_idx;
            r_trec       <= n_trec;
            r_hrec       <= n_hrec;
            r_valid      <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && r_collecting) begin
            r_tsamp[r_idx] <= tc;
            r_hsamp[r_idx] <= hc;
        end
        if (produce) begin
            r_res.temp   <= t_fin;
            r_res.hum    <= h_fin;
            r_res.failed <= !ok_cand;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

FILE: hw/rtl/hto_tenths.sv
// Scaling stages: fixed-point values to tenths by reciprocal multiply, then output register.
// Depends on hto_pkg; drives the result channel of the top level.
module hto_tenths (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  hto_pkg::t_res      i_res,
    output logic               o_ready,
    input  logic               i_stall,
    output logic               o_valid,
    output hto_pkg::t_out_item o_data
);

    localparam int PROD_W = hto_pkg::HUM_W + hto_pkg::RECIP_W;

    typedef struct packed {
        logic [hto_pkg::QUOT_W-1:0] qt;
        logic [hto_pkg::QUOT_W-1:0] qh;
        logic                       neg;
        logic                       failed;
    } t_quot;

    logic  r_mul_valid, n_mul_valid;
    logic  r_out_valid, n_out_valid;
    t_quot r_mul;
    hto_pkg::t_out_item r_out, n_out;

    logic mul_ready, out_ready, take, load_out;
    logic [hto_pkg::HUM_W-1:0] t_mag;
    logic [PROD_W-1:0] t_prod, h_prod;
    logic [11:0] qt_ext;

    assign out_ready = !r_out_valid || !i_stall;
    assign mul_ready = !r_mul_valid || out_ready;
    assign take      = i_valid && mul_ready;
    assign load_out  = r_mul_valid && out_ready;

    assign t_mag  = i_res.temp[hto_pkg::TEMP_W-1] ? hto_pkg::HUM_W'(-i_res.temp)
                                                  : hto_pkg::HUM_W'(i_res.temp);
    assign t_prod = PROD_W'(t_mag) * PROD_W'(hto_pkg::RECIP);
    assign h_prod = PROD_W'(i_res.hum) * PROD_W'(hto_pkg::RECIP);

    assign qt_ext = {1'b0, r_mul.qt};

    always_comb begin
        n_out.read_failed = r_mul.failed;
        if (r_mul.failed) begin
            n_out.temp_tenths = hto_pkg::FAULT_TEMP_TENTHS;
            n_out.hum_tenths  = 10'd0;
        end else begin
            n_out.temp_tenths = r_mul.neg ? $signed(-qt_ext) : $signed(qt_ext);
            n_out.hum_tenths  = r_mul.qh[9:0];
        end
    end

    always_comb begin
        n_mul_valid = take ? 1'b1 : (load_out ? 1'b0 : r_mul_valid);
        n_out_valid = load_out ? 1'b1 : ((r_out_valid && !i_stall) ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mul_valid <= n_mul_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_mul.qt     <= t_prod[hto_pkg::DIV_SHIFT +: hto_pkg::QUOT_W];
            r_mul.qh     <= h_prod[hto_pkg::DIV_SHIFT +: hto_pkg::QUOT_W];
            r_mul.neg    <= i_res.temp[hto_pkg::TEMP_W-1];
            r_mul.failed <= i_res.failed;
        end
        if (load_out) begin
            r_out <= n_out;
        end
    end

    assign o_ready = mul_ready;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

FILE: hw/rtl/humidity_temp_outlier_filter.sv
// Top level of the humidity/temperature outlier filter.
// Depends on hto_pkg, hto_filter and hto_tenths.
//
// Usage:
//   Request channel: i_in_valid / i_in_data / o_in_stall. A reading is taken at a rising
//   edge with i_in_valid high and o_in_stall low.
//   Result channel: o_out_valid / o_out_data / i_out_stall. A result is taken at a
//   rising edge with o_out_valid high and i_out_stall low.
//   Configuration: i_cfg_valid / i_cfg_index / i_cfg_data / o_cfg_ready, ready always
//   high; write only while no request is in flight.
//   One request per cycle is accepted while o_in_stall is low. A request that yields a
//   result passes the input register, filter register, reciprocal-multiply register and
//   output register before it shows on the result channel. Requests that start or
//   continue a resampling burst yield no result.
//   The jump and humidity limits are held pre-scaled.
//   Reset clears the pipeline, returns to normal mode and restores records and limits.
//   A stall from the receiver holds the output register and backs up through the
//   stages; o_in_stall rises only once every stage is full.
module humidity_temp_outlier_filter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  hto_pkg::t_in_item  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output hto_pkg::t_out_item o_out_data,
    input  logic               i_out_stall,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    output logic               o_cfg_ready
);

    hto_pkg::t_cfg     r_cfg, n_cfg;
    hto_pkg::t_in_item r_in;
    logic              r_in_valid, n_in_valid;

    logic          res_valid, mul_ready, res_ready, in_ready, accept, take, adv;
    hto_pkg::t_res res;

    assign res_ready = !res_valid || mul_ready;
    assign in_ready  = !r_in_valid || res_ready;
    assign accept    = i_in_valid && in_ready;
    assign take      = r_in_valid && res_ready;
    assign adv       = res_valid && mul_ready;

    always_comb begin
        n_in_valid = accept ? 1'b1 : (take ? 1'b0 : r_in_valid);
    end

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (hto_pkg::t_cfg_idx'(i_cfg_index))
                hto_pkg::CFG_TEMP_JUMP: n_cfg.temp_jump = 26'(i_cfg_data) * 26'(hto_pkg::UNIT);
                hto_pkg::CFG_HUM_JUMP:  n_cfg.hum_jump  = 24'(i_cfg_data[6:0]) * 24'(hto_pkg::UNIT);
                hto_pkg::CFG_HUM_LOW:   n_cfg.hum_low   = 24'(i_cfg_data[6:0]) * 24'(hto_pkg::UNIT);
                default:                n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_cfg.temp_jump <= hto_pkg::TEMP_JUMP_RESET;
            r_cfg.hum_jump  <= hto_pkg::HUM_JUMP_RESET;
            r_cfg.hum_low   <= hto_pkg::HUM_LOW_RESET;
        end else begin
            r_in_valid <= n_in_valid;
            r_cfg      <= n_cfg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_data;
        end
    end

    hto_filter u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_take  (take),
        .i_item  (r_in),
        .i_adv   (adv),
        .o_valid (res_valid),
        .o_res   (res)
    );

    hto_tenths u_tenths (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_res   (res),
        .o_ready (mul_ready),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

    assign o_in_stall  = !in_ready;
    assign o_cfg_ready = 1'b1;

endmodule

FILE: hw/rtl/hto_checker.sv
// Port-level checker for the outlier filter, bound to the top level.
// Depends on hto_pkg and humidity_temp_outlier_filter.
module hto_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input hto_pkg::t_out_item o_out_data,
    input logic               i_out_stall
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_fault_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.read_failed |->
            o_out_data.temp_tenths == hto_pkg::FAULT_TEMP_TENTHS && o_out_data.hum_tenths == 10'd0)
        else $error("failed read without fault values");

    a_good_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.read_failed |->
            o_out_data.temp_tenths >= -12'sd400 && o_out_data.temp_tenths <= 12'sd1250
            && o_out_data.hum_tenths <= 10'd999)
        else $error("good result out of range");

endmodule

bind humidity_temp_outlier_filter hto_checker u_hto_checker (.*);
